// ===== src/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and constants for the polygon nearest point projection core.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int FACTOR_FRAC_BITS = 16;
  localparam int FACTOR_W         = FACTOR_FRAC_BITS + 1;
  localparam int COORD_W          = 24;
  localparam int MUL_W            = 26;
  localparam int PROD_W           = 2 * MUL_W;
  localparam int SQ_W             = 50;
  localparam int ROOT_W           = SQ_W / 2;
  localparam int DSQ_W            = 51;
  localparam int PERIM_W          = 34;

  localparam logic [8:0] VCOUNT_RESET = 9'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ITER_DIV  = 1'b0;
  localparam logic ITER_SQRT = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic [7:0]                 vertex_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
  } in_t;

  typedef struct packed {
    logic                       found;
    logic [7:0]                 segment_index;
    logic [16:0]                segment_factor;
    logic [32:0]                perimeter_position;
    logic [24:0]                distance;
    logic signed [COORD_W-1:0]  near_x;
    logic signed [COORD_W-1:0]  near_y;
  } out_t;

  typedef struct packed {
    logic start;
    logic mode;
  } iter_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } iter_rsp_t;

endpackage

// ===== src/ppr_mul.sv =====
// ----------------------------------------------------------------------------
// ppr_mul
// Shared signed multiplier, product registered.
// ----------------------------------------------------------------------------
module ppr_mul (
  input  logic                                clk_i,
  input  logic signed [ppr_pkg::MUL_W-1:0]    a_i,
  input  logic signed [ppr_pkg::MUL_W-1:0]    b_i,
  output logic signed [ppr_pkg::PROD_W-1:0]   p_o
);

  logic signed [ppr_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== src/ppr_iter.sv =====
// ----------------------------------------------------------------------------
// ppr_iter
// Bit-serial unit: restoring fraction divide or integer square root.
// ----------------------------------------------------------------------------
module ppr_iter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ppr_pkg::iter_req_t           req_i,
  input  logic [ppr_pkg::SQ_W-1:0]     num_i,
  input  logic [ppr_pkg::SQ_W-1:0]     den_i,
  output ppr_pkg::iter_rsp_t           rsp_o
);

  localparam int RW = ppr_pkg::SQ_W + 2;
  localparam int NW = ppr_pkg::ROOT_W;

  logic                      busy_q, done_q, mode_q;
  logic [4:0]                cnt_q;
  logic [RW-1:0]             rem_q, rem_d;
  logic [ppr_pkg::SQ_W-1:0]  den_q, src_q;
  logic [NW-1:0]             root_q, root_d;
  logic [RW-1:0]             shifted, trial;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    if (mode_q == ppr_pkg::ITER_DIV) begin
      shifted = {rem_q[RW-2:0], 1'b0};
      trial   = {2'b00, den_q};
    end else begin
      shifted = {rem_q[RW-3:0], src_q[ppr_pkg::SQ_W-1 -: 2]};
      trial   = RW'({root_q, 2'b01});
    end
    if (shifted >= trial) begin
      rem_d  = shifted - trial;
      root_d = {root_q[NW-2:0], 1'b1};
    end else begin
      rem_d  = shifted;
      root_d = {root_q[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd0);
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 5'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      root_q <= '0;
      den_q  <= den_i;
      src_q  <= num_i;
      if (req_i.mode == ppr_pkg::ITER_DIV) begin
        rem_q <= {2'b00, num_i};
        cnt_q <= 5'(ppr_pkg::FACTOR_FRAC_BITS - 1);
      end else begin
        rem_q <= '0;
        cnt_q <= 5'(NW - 1);
      end
    end else if (busy_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      src_q  <= {src_q[ppr_pkg::SQ_W-3:0], 2'b00};
      cnt_q  <= cnt_q - 5'd1;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = root_q;

endmodule

// ===== src/polygon_nearest_point_projection_core.sv =====
// ----------------------------------------------------------------------------
// polygon_nearest_point_projection_core
// Nearest point on a closed polygon held in an on-chip vertex store.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): a load transfer writes
// one vertex and gives no result. A query transfer walks every
// edge of the polygon, the closing edge included, and gives one result on the
// output channel (out_valid_o / out_stall_i / out_data_o).
// All arithmetic runs on one registered multiplier and one bit-serial
// divide/square-root unit under a sequencer; in_stall_o is high for the
// whole query. An edge runs the factor divide, the edge length root, nine
// multiplies, the store read and the update. An edge whose factor clamps
// skips the divide; a degenerate edge skips the divide, the root, the
// last five multiplies and the update. A query ends with the root of the
// best squared distance, skipped when nothing is found.
// Loads go back to back.
// The result sits in an output register: the next item is taken while it
// waits, and a finished query holds in its last state until that register is
// free. Reset sets the vertex count to 4 and clears the output valid; the
// vertex store is undefined until loaded.
// ----------------------------------------------------------------------------
module polygon_nearest_point_projection_core #(
  parameter int MAX_VERTICES = ppr_pkg::DEF_MAX_VERTICES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ppr_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ppr_pkg::out_t   out_data_o,
  input  logic            cfg_we_i,
  input  logic [8:0]      cfg_wdata_i
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int F   = ppr_pkg::FACTOR_FRAC_BITS;
  localparam int FW  = ppr_pkg::FACTOR_W;
  localparam int CDW = ppr_pkg::COORD_W;
  localparam int MW  = ppr_pkg::MUL_W;
  localparam int PW  = ppr_pkg::PROD_W;
  localparam int SW  = ppr_pkg::SQ_W;
  localparam int RTW = ppr_pkg::ROOT_W;
  localparam int DW  = ppr_pkg::DSQ_W;
  localparam int PMW = ppr_pkg::PERIM_W;

  localparam logic [FW-1:0] FACTOR_ONE  = FW'(1) << F;
  localparam logic [PW-1:0] FACTOR_HALF = PW'(1) << (F - 1);
  localparam logic [DW-1:0] DIST_NONE   = '1;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_FIRST  = 5'd1;
  localparam logic [4:0] ST_RDNEXT = 5'd2;
  localparam logic [4:0] ST_DIFF   = 5'd3;
  localparam logic [4:0] ST_MDX    = 5'd4;
  localparam logic [4:0] ST_MDY    = 5'd5;
  localparam logic [4:0] ST_MQX    = 5'd6;
  localparam logic [4:0] ST_MQY    = 5'd7;
  localparam logic [4:0] ST_DOT    = 5'd8;
  localparam logic [4:0] ST_DIV    = 5'd9;
  localparam logic [4:0] ST_SQRT   = 5'd10;
  localparam logic [4:0] ST_MNX    = 5'd11;
  localparam logic [4:0] ST_MNY    = 5'd12;
  localparam logic [4:0] ST_MEX    = 5'd13;
  localparam logic [4:0] ST_MEY    = 5'd14;
  localparam logic [4:0] ST_MLEN   = 5'd15;
  localparam logic [4:0] ST_UPD    = 5'd16;
  localparam logic [4:0] ST_NEXT   = 5'd17;
  localparam logic [4:0] ST_FIN    = 5'd18;
  localparam logic [4:0] ST_SQF    = 5'd19;
  localparam logic [4:0] ST_OUT    = 5'd20;

  logic [4:0]                 state_q, state_d;
  logic [8:0]                 vcount_q;
  logic                       out_valid_q;
  ppr_pkg::out_t              out_q;

  logic signed [CDW-1:0]      mem_x [MAX_VERTICES];
  logic signed [CDW-1:0]      mem_y [MAX_VERTICES];
  logic signed [CDW-1:0]      rd_x_q, rd_y_q;
  logic [AW-1:0]              rd_addr;

  logic signed [CDW-1:0]      px_q, py_q, sx_q, sy_q, ex_q, ey_q, nx_q, ny_q;
  logic signed [CDW:0]        dx_q, dy_q, qx_q, qy_q;
  logic [AW-1:0]              i_q, j;
  logic [CW-1:0]              n;
  logic signed [PW-1:0]       acc_q, p, dot_s;
  logic [SW-1:0]              lsq_q;
  logic [DW-1:0]              dsq_q, best_dsq_q;
  logic [FW-1:0]              f_q, best_f_q;
  logic [RTW-1:0]             len_q, dist_q;
  logic [PMW-1:0]             run_q, best_per_q;
  logic [AW-1:0]              best_i_q;
  logic signed [CDW-1:0]      best_nx_q, best_ny_q;

  logic signed [MW-1:0]       mul_a, mul_b;
  logic signed [MW-1:0]       abs_dx, abs_dy;
  logic signed [MW-1:0]       ex_m, ey_m;
  logic [PW-1:0]              round_full;
  logic signed [MW-1:0]       round_m, near_c;
  logic                       in_xfer, out_xfer, last_edge, found;

  ppr_pkg::iter_req_t         iter_req;
  ppr_pkg::iter_rsp_t         iter_rsp;
  logic [SW-1:0]              iter_num;

  ppr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  ppr_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .num_i  (iter_num),
    .den_i  (lsq_q),
    .rsp_o  (iter_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign n = (32'(vcount_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_q);
  assign j = (32'(i_q) + 1 < 32'(n)) ? i_q + AW'(1) : '0;
  assign last_edge = (32'(i_q) + 1 >= 32'(n));
  assign found = (best_dsq_q != DIST_NONE);

  assign abs_dx = dx_q[CDW] ? -MW'(dx_q) : MW'(dx_q);
  assign abs_dy = dy_q[CDW] ? -MW'(dy_q) : MW'(dy_q);
  assign ex_m   = MW'(px_q) - MW'(nx_q);
  assign ey_m   = MW'(py_q) - MW'(ny_q);
  assign dot_s  = acc_q + p;

  // magnitude rounded half away from zero, then signed back on
  assign round_full = PW'(p) + FACTOR_HALF;
  assign round_m    = MW'(round_full >> F);

  always_comb begin
    rd_addr = '0;
    if (state_q == ST_RDNEXT) begin
      rd_addr = j;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MDX:  begin mul_a = MW'(dx_q); mul_b = MW'(dx_q); end
      ST_MDY:  begin mul_a = MW'(dy_q); mul_b = MW'(dy_q); end
      ST_MQX:  begin mul_a = MW'(qx_q); mul_b = MW'(dx_q); end
      ST_MQY:  begin mul_a = MW'(qy_q); mul_b = MW'(dy_q); end
      ST_MNX:  begin mul_a = abs_dx;    mul_b = MW'(f_q);  end
      ST_MNY:  begin mul_a = abs_dy;    mul_b = MW'(f_q);  end
      ST_MEX:  begin mul_a = ex_m;      mul_b = ex_m;      end
      ST_MEY:  begin mul_a = ey_m;      mul_b = ey_m;      end
      ST_MLEN: begin mul_a = MW'(len_q); mul_b = MW'(f_q); end
      default: begin mul_a = '0;        mul_b = '0;        end
    endcase
  end

  always_comb begin
    near_c = '0;
    if (state_q == ST_MNY) begin
      near_c = dx_q[CDW] ? MW'(sx_q) - round_m : MW'(sx_q) + round_m;
    end else if (state_q == ST_MEX) begin
      near_c = dy_q[CDW] ? MW'(sy_q) - round_m : MW'(sy_q) + round_m;
    end
  end

  always_comb begin
    state_d        = state_q;
    iter_req.start = 1'b0;
    iter_req.mode  = ppr_pkg::ITER_SQRT;
    iter_num       = lsq_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_data_i.operation == ppr_pkg::OP_QUERY) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST:  state_d = (n == '0) ? ST_FIN : ST_RDNEXT;
      ST_RDNEXT: state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_MDX;
      ST_MDX:    state_d = ST_MDY;
      ST_MDY:    state_d = ST_MQX;
      ST_MQX:    state_d = ST_MQY;
      ST_MQY:    state_d = ST_DOT;
      ST_DOT: begin
        priority if (lsq_q == '0) begin
          state_d = ST_NEXT;
        end else if (dot_s <= 0 || dot_s >= $signed(PW'(lsq_q))) begin
          iter_req.start = 1'b1;
          state_d        = ST_SQRT;
        end else begin
          iter_req.start = 1'b1;
          iter_req.mode  = ppr_pkg::ITER_DIV;
          iter_num       = SW'(dot_s);
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (iter_rsp.done) begin
          iter_req.start = 1'b1;
          state_d        = ST_SQRT;
        end
      end
      ST_SQRT: if (iter_rsp.done) state_d = ST_MNX;
      ST_MNX:  state_d = ST_MNY;
      ST_MNY:  state_d = ST_MEX;
      ST_MEX:  state_d = ST_MEY;
      ST_MEY:  state_d = ST_MLEN;
      ST_MLEN: state_d = ST_UPD;
      ST_UPD:  state_d = ST_NEXT;
      ST_NEXT: state_d = last_edge ? ST_FIN : ST_RDNEXT;
      ST_FIN: begin
        if (found) begin
          iter_req.start = 1'b1;
          iter_num       = best_dsq_q[SW-1:0];
          state_d        = ST_SQF;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SQF:  if (iter_rsp.done) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= ppr_pkg::VCOUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // vertex store
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.operation == ppr_pkg::OP_LOAD &&
        32'(in_data_i.vertex_index) < MAX_VERTICES) begin
      mem_x[AW'(in_data_i.vertex_index)] <= in_data_i.coord_x;
      mem_y[AW'(in_data_i.vertex_index)] <= in_data_i.coord_y;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        px_q       <= in_data_i.coord_x;
        py_q       <= in_data_i.coord_y;
        run_q      <= '0;
        best_dsq_q <= DIST_NONE;
        best_i_q   <= '0;
        best_f_q   <= '0;
        best_per_q <= '0;
        best_nx_q  <= '0;
        best_ny_q  <= '0;
        dist_q     <= '0;
        i_q        <= '0;
      end
      ST_FIRST: begin
        sx_q <= rd_x_q;
        sy_q <= rd_y_q;
      end
      ST_DIFF: begin
        ex_q <= rd_x_q;
        ey_q <= rd_y_q;
        dx_q <= (CDW+1)'(rd_x_q) - (CDW+1)'(sx_q);
        dy_q <= (CDW+1)'(rd_y_q) - (CDW+1)'(sy_q);
        qx_q <= (CDW+1)'(px_q) - (CDW+1)'(sx_q);
        qy_q <= (CDW+1)'(py_q) - (CDW+1)'(sy_q);
      end
      ST_MDY:  acc_q <= p;
      ST_MQX:  lsq_q <= SW'(acc_q + p);
      ST_MQY:  acc_q <= p;
      ST_DOT: begin
        if (dot_s <= 0) begin
          f_q <= '0;
        end else begin
          f_q <= FACTOR_ONE;
        end
      end
      ST_DIV:  if (iter_rsp.done) f_q <= FW'(iter_rsp.result);
      ST_SQRT: if (iter_rsp.done) len_q <= iter_rsp.result;
      ST_MNY:  nx_q <= CDW'(near_c);
      ST_MEX:  ny_q <= CDW'(near_c);
      ST_MEY:  acc_q <= p;
      ST_MLEN: dsq_q <= DW'(acc_q + p);
      ST_UPD: begin
        if (dsq_q < best_dsq_q) begin
          best_dsq_q <= dsq_q;
          best_i_q   <= i_q;
          best_f_q   <= f_q;
          best_nx_q  <= nx_q;
          best_ny_q  <= ny_q;
          best_per_q <= run_q + PMW'(round_full >> F);
        end
        run_q <= run_q + PMW'(len_q);
      end
      ST_NEXT: begin
        sx_q <= ex_q;
        sy_q <= ey_q;
        i_q  <= i_q + AW'(1);
      end
      ST_SQF:  if (iter_rsp.done) dist_q <= iter_rsp.result;
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q.found              <= found;
          out_q.segment_index      <= found ? 8'(best_i_q) : '0;
          out_q.segment_factor     <= found ? best_f_q : '0;
          out_q.perimeter_position <= found ? best_per_q[32:0] : '0;
          out_q.distance           <= found ? dist_q : '0;
          out_q.near_x             <= found ? best_nx_q : '0;
          out_q.near_y             <= found ? best_ny_q : '0;
        end
      end
      default: ;
    endcase
  end

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result register loaded outside the result state");

  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> 32'(i_q) < 32'(n))
    else $error("edge index beyond vertex count");

  a_iter_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_rsp.done |-> (state_q == ST_DIV || state_q == ST_SQRT || state_q == ST_SQF))
    else $error("iterative unit finished while sequencer not waiting");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.operation == ppr_pkg::OP_QUERY |=> in_stall_o)
    else $error("query accepted without blocking the input");

endmodule

// ===== sim/polygon_nearest_point_projection_core_tb.sv =====
// ----------------------------------------------------------------------------
// polygon_nearest_point_projection_core_tb
// Loads polygons into the vertex store, projects query points onto them and
// checks every result field against a behavioral predictor of the core.
// ----------------------------------------------------------------------------
module polygon_nearest_point_projection_core_tb;

  localparam int MAXV = 256;
  localparam int FB   = ppr_pkg::FACTOR_FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 100000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  ppr_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  ppr_pkg::out_t out_data_o;
  logic          cfg_we_i;
  logic [8:0]    cfg_wdata_i;

  polygon_nearest_point_projection_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  longint        poly_x [MAXV];
  longint        poly_y [MAXV];
  logic [8:0]    vcount_model;

  ppr_pkg::out_t projection_queue [$];
  int            error_count;
  int            idle_cycles;

  typedef struct {
    logic          operation;
    logic [7:0]    index;
    longint        x;
    longint        y;
    bit            typed;
    ppr_pkg::out_t expected;
  } stim_row_t;

  stim_row_t     directed_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned edge_factor(longint dot, longint unsigned lsq);
    longint unsigned r, q;
    if (dot <= 0) return 0;
    if (longint'(lsq) <= dot) return 64'd1 << FB;
    r = dot;
    q = 0;
    for (int i = 0; i < FB; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= lsq) begin
        r -= lsq;
        q |= 1;
      end
    end
    return q;
  endfunction

  // magnitude rounded half away from zero
  function automatic longint scale_axis(longint d, longint unsigned f);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    m = (m * f + (64'd1 << (FB - 1))) >> FB;
    return (d < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic ppr_pkg::out_t project_point(longint px, longint py);
    ppr_pkg::out_t   res;
    int              n, j;
    longint          sx, sy, dx, dy, nx, ny, ex, ey, bnx, bny;
    longint unsigned lsq, f, len, dsq, perim, best_dsq, best_f, best_perim;
    int              best_i;
    n = (vcount_model > MAXV) ? MAXV : vcount_model;
    perim = 0;
    best_dsq = 64'h7FFFFFFFFFFFF;
    best_i = 0;
    best_f = 0;
    best_perim = 0;
    bnx = 0;
    bny = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      sx = poly_x[i];
      sy = poly_y[i];
      dx = poly_x[j] - sx;
      dy = poly_y[j] - sy;
      lsq = dx * dx + dy * dy;
      if (lsq == 0) continue;
      f = edge_factor((px - sx) * dx + (py - sy) * dy, lsq);
      nx = sx + scale_axis(dx, f);
      ny = sy + scale_axis(dy, f);
      ex = px - nx;
      ey = py - ny;
      dsq = ex * ex + ey * ey;
      len = int_sqrt(lsq);
      if (dsq < best_dsq) begin
        best_dsq = dsq;
        best_i = i;
        best_f = f;
        best_perim = (perim + ((len * f + (64'd1 << (FB - 1)))
                      >> FB)) & 64'h3FFFFFFFF;
        bnx = nx;
        bny = ny;
      end
      perim = (perim + len) & 64'h3FFFFFFFF;
    end
    res = '0;
    if (best_dsq != 64'h7FFFFFFFFFFFF) begin
      res.found              = 1'b1;
      res.segment_index      = best_i[7:0];
      res.segment_factor     = best_f[16:0];
      res.perimeter_position = best_perim[32:0];
      res.distance           = 25'(int_sqrt(best_dsq));
      res.near_x             = bnx[23:0];
      res.near_y             = bny[23:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // drive one transfer; the model is updated at acceptance
  task automatic send_item(logic op, logic [7:0] idx, longint x, longint y,
                           bit typed, ppr_pkg::out_t typed_res);
    int            gap;
    ppr_pkg::out_t exp_res;
    gap = $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i.operation    <= op;
    in_data_i.vertex_index <= idx;
    in_data_i.coord_x      <= x[23:0];
    in_data_i.coord_y      <= y[23:0];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == ppr_pkg::OP_LOAD) begin
      poly_x[idx] = x;
      poly_y[idx] = y;
    end else begin
      exp_res = project_point(x, y);
      if (typed && exp_res != typed_res) report_mismatch("table row", 0, 1);
      projection_queue.insert(projection_queue.size(), exp_res);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (projection_queue.size() != 0) @(negedge clk_i);
    // let the core go quiet before the next phase
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_vcount(logic [8:0] v);
    drain_and_settle();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    vcount_model = v;
  endtask

  function automatic longint rand_coord(int span);
    if ($urandom_range(0, 9) == 0)
      return longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic load_polygon(int n, int span);
    for (int i = 0; i < n; i++)
      send_item(ppr_pkg::OP_LOAD, i[7:0], rand_coord(span), rand_coord(span),
                1'b0, '0);
  endtask

  // output side: random stall count before each result transfer
  initial begin
    int wait_cycles;
    out_stall_i = 1'b1;
    forever begin
      wait_cycles = $urandom_range(0, 11);
      repeat (wait_cycles) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    ppr_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (projection_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = projection_queue.pop_front();
        if (out_data_o.found !== want.found)
          report_mismatch("found", out_data_o.found, want.found);
        if (out_data_o.segment_index !== want.segment_index)
          report_mismatch("segment_index", out_data_o.segment_index, want.segment_index);
        if (out_data_o.segment_factor !== want.segment_factor)
          report_mismatch("segment_factor", out_data_o.segment_factor,
                          want.segment_factor);
        if (out_data_o.perimeter_position !== want.perimeter_position)
          report_mismatch("perimeter_position", out_data_o.perimeter_position,
                          want.perimeter_position);
        if (out_data_o.distance !== want.distance)
          report_mismatch("distance", out_data_o.distance, want.distance);
        if (out_data_o.near_x !== want.near_x)
          report_mismatch("near_x", out_data_o.near_x, want.near_x);
        if (out_data_o.near_y !== want.near_y)
          report_mismatch("near_y", out_data_o.near_y, want.near_y);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_row(logic op, int idx, longint x, longint y,
                         bit typed, ppr_pkg::out_t res);
    stim_row_t r;
    r.operation = op;
    r.index = idx[7:0];
    r.x = x;
    r.y = y;
    r.typed = typed;
    r.expected = res;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  initial begin
    ppr_pkg::out_t none_found;
    ppr_pkg::out_t corner_hit;
    int            n;
    idle_cycles = 0;
    error_count = 0;
    vcount_model = ppr_pkg::VCOUNT_RESET;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    none_found = '0;
    // query at vertex 0 of a square: first edge, factor 0, distance 0
    corner_hit = '0;
    corner_hit.found = 1'b1;
    corner_hit.near_x = 24'sd0;
    corner_hit.near_y = 24'sd0;

    // square of 256 on reset vertex count, then extremes
    add_row(ppr_pkg::OP_LOAD, 0, 0, 0, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 1, 256, 0, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 2, 256, 256, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 3, 0, 256, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, 0, 0, 1'b1, corner_hit);
    add_row(ppr_pkg::OP_QUERY, 255, 128, -500, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, 128, 128, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, 8388607, 8388607, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, -8388608, -8388608, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, -100, 300, 1'b0, '0);
    // coordinate extremes as vertices
    add_row(ppr_pkg::OP_LOAD, 0, -8388608, -8388608, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 1, 8388607, -8388608, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 2, 8388607, 8388607, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 3, -8388608, 8388607, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, 0, 0, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, 8388607, -8388608, 1'b0, '0);
    // all-same polygon: every edge degenerate
    add_row(ppr_pkg::OP_LOAD, 0, 5, 5, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 1, 5, 5, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 2, 5, 5, 1'b0, '0);
    add_row(ppr_pkg::OP_LOAD, 3, 5, 5, 1'b0, '0);
    add_row(ppr_pkg::OP_QUERY, 0, 9, -9, 1'b1, none_found);

    foreach (directed_rows[k])
      send_item(directed_rows[k].operation, directed_rows[k].index,
                directed_rows[k].x, directed_rows[k].y,
                directed_rows[k].typed, directed_rows[k].expected);

    // vertex count zero and one
    write_vcount(9'd0);
    send_item(ppr_pkg::OP_QUERY, 8'd0, 1, 1, 1'b1, none_found);
    write_vcount(9'd1);
    send_item(ppr_pkg::OP_QUERY, 8'd0, 1, 1, 1'b1, none_found);
    // two vertices, partly repeated edges
    write_vcount(9'd2);
    send_item(ppr_pkg::OP_LOAD, 8'd1, -40, 77, 1'b0, '0);
    send_item(ppr_pkg::OP_QUERY, 8'd0, 3, 3, 1'b0, '0);

    // random phases: mostly small polygons with random queries
    for (int phase = 0; phase < 6; phase++) begin
      n = (phase % 3 == 2) ? $urandom_range(12, 16) : $urandom_range(2, 8);
      write_vcount(n[8:0]);
      load_polygon(n, (phase % 2) ? 8388607 : 3000);
      for (int q = 0; q < 6; q++) begin
        if ($urandom_range(0, 5) == 0)
          // reload a random vertex with new content
          send_item(ppr_pkg::OP_LOAD, 8'($urandom_range(0, n - 1)),
                    rand_coord(3000), rand_coord(3000), 1'b0, '0);
        else
          send_item(ppr_pkg::OP_QUERY, 8'($urandom_range(0, 255)),
                    rand_coord(5000), rand_coord(5000), 1'b0, '0);
      end
    end

    drain_and_settle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
